/* rtl/u8u16_pkg.sv */
// Shared types and constants for the UTF-8 to UTF-16 transcoder.
// No dependencies; imported by the front, back and top-level modules.
package u8u16_pkg;

    // Most code units that one input byte can produce
    localparam int unsigned MAX_WORDS = 4;
    localparam int unsigned IDX_W     = $clog2(MAX_WORDS);
    localparam int unsigned WORD_W    = 16;
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned CODE_W    = 21;

    // Error replacement character '?'
    localparam logic [WORD_W-1:0] QMARK       = 16'h003F;
    localparam logic [WORD_W-1:0] HI_SURR     = 16'hD800;
    localparam logic [WORD_W-1:0] LO_SURR     = 16'hDC00;
    localparam logic [19:0]       SUPP_OFFSET = 20'h10000;
    // Top five bits of the highest code point, 0x10FFFF
    localparam logic [4:0]        PLANE_MAX   = 5'h10;

    // Byte class masks and patterns
    localparam logic [BYTE_W-1:0] CONT_MASK = 8'hC0;
    localparam logic [BYTE_W-1:0] CONT_PAT  = 8'h80;
    localparam logic [BYTE_W-1:0] LEAD2_MSK = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD2_PAT = 8'hC0;
    localparam logic [BYTE_W-1:0] LEAD3_MSK = 8'hF0;
    localparam logic [BYTE_W-1:0] LEAD3_PAT = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD4_MSK = 8'hF8;
    localparam logic [BYTE_W-1:0] LEAD4_PAT = 8'hF0;

    // Work list for one byte: the code units to emit and the index of the last one
    typedef struct packed {
        logic [IDX_W-1:0]                last_idx;
        logic [MAX_WORDS-1:0][WORD_W-1:0] word;
    } t_cmd;

endpackage

/* rtl/u8u16_queue.sv */
// Small synchronous FIFO between the decoder front and the emitter back.
// Generic; no package dependency.
module u8u16_queue #(
    parameter int unsigned WIDTH = 66,
    parameter int unsigned DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             w_push, w_pop;

    assign o_full  = (r_count == FULL_CNT);
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    // Pointer and fill-count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("queue fill count beyond depth");
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full && !w_pop |=> o_full)
        else $error("queue left full without a pop");
    a_ptr_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0 || r_count == FULL_CNT) |-> r_wr_ptr == r_rd_ptr)
        else $error("queue pointers disagree with fill count");

endmodule

/* rtl/u8u16_front.sv */
// Decoder front: accepts UTF-8 bytes, tracks the pending sequence and
// builds the list of UTF-16 code units per byte. Uses u8u16_pkg.
module u8u16_front (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [7:0]               i_in_byte,
    input  logic                     i_is_last,
    input  logic                     i_q_full,
    output logic                     o_push,
    output u8u16_pkg::t_cmd          o_cmd
);
    import u8u16_pkg::*;

    logic [CODE_W-1:0] r_code_acc, n_code_acc;
    logic [1:0]        r_bytes_needed, n_bytes_needed;
    logic [1:0]        r_bytes_seen, n_bytes_seen;
    logic [2:0]        w_count;
    logic              w_accept;
    logic [CODE_W-1:0] w_acc_ext;
    logic [19:0]       w_supp;
    logic              w_is_cont;
    logic              w_fresh;

    assign o_ready   = !i_q_full;
    assign w_accept  = i_valid && o_ready;
    assign w_is_cont = ((i_in_byte & CONT_MASK) == CONT_PAT);
    assign w_acc_ext = {r_code_acc[CODE_W-7:0], i_in_byte[5:0]};
    assign w_supp    = w_acc_ext[19:0] - SUPP_OFFSET;

    // Decode one byte: words default to '?', only real code units are placed
    always_comb begin
        n_code_acc     = r_code_acc;
        n_bytes_needed = r_bytes_needed;
        n_bytes_seen   = r_bytes_seen;
        w_count        = '0;
        w_fresh        = 1'b1;
        o_cmd.word     = {MAX_WORDS{QMARK}};

        if (r_bytes_needed != 2'd0) begin
            if (w_is_cont) begin
                w_fresh = 1'b0;
                if (r_bytes_needed == 2'd1) begin
                    // sequence complete
                    n_code_acc     = '0;
                    n_bytes_needed = '0;
                    n_bytes_seen   = '0;
                    if (w_acc_ext[20:16] == 5'd0) begin
                        o_cmd.word[0] = w_acc_ext[15:0];
                        w_count       = 3'd1;
                    end else if (w_acc_ext[20:16] <= PLANE_MAX) begin
                        o_cmd.word[0] = HI_SURR | {6'd0, w_supp[19:10]};
                        o_cmd.word[1] = LO_SURR | {6'd0, w_supp[9:0]};
                        w_count       = 3'd2;
                    end else begin
                        w_count = 3'd1;
                    end
                end else begin
                    n_code_acc     = w_acc_ext;
                    n_bytes_needed = r_bytes_needed - 1'b1;
                    n_bytes_seen   = r_bytes_seen + 1'b1;
                end
            end else begin
                // cut-off sequence: one '?' per byte taken
                w_count        = {1'b0, r_bytes_seen};
                n_code_acc     = '0;
                n_bytes_needed = '0;
                n_bytes_seen   = '0;
            end
        end

        if (w_fresh) begin
            if (!i_in_byte[7]) begin
                o_cmd.word[w_count[IDX_W-1:0]] = {8'd0, i_in_byte};
                w_count = w_count + 3'd1;
            end else if ((i_in_byte & LEAD2_MSK) == LEAD2_PAT) begin
                n_code_acc     = {16'd0, i_in_byte[4:0]};
                n_bytes_needed = 2'd1;
                n_bytes_seen   = 2'd1;
            end else if ((i_in_byte & LEAD3_MSK) == LEAD3_PAT) begin
                n_code_acc     = {17'd0, i_in_byte[3:0]};
                n_bytes_needed = 2'd2;
                n_bytes_seen   = 2'd1;
            end else if ((i_in_byte & LEAD4_MSK) == LEAD4_PAT) begin
                n_code_acc     = {18'd0, i_in_byte[2:0]};
                n_bytes_needed = 2'd3;
                n_bytes_seen   = 2'd1;
            end else begin
                // lone continuation or invalid lead
                w_count = w_count + 3'd1;
            end
        end

        // end of string flushes what is still pending
        if (i_is_last && n_bytes_needed != 2'd0) begin
            w_count        = w_count + {1'b0, n_bytes_seen};
            n_code_acc     = '0;
            n_bytes_needed = '0;
            n_bytes_seen   = '0;
        end

        o_cmd.last_idx = w_count[IDX_W-1:0] - 1'b1;
        o_push         = w_accept && (w_count != 3'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_code_acc     <= '0;
            r_bytes_needed <= '0;
            r_bytes_seen   <= '0;
        end else if (w_accept) begin
            r_code_acc     <= n_code_acc;
            r_bytes_needed <= n_bytes_needed;
            r_bytes_seen   <= n_bytes_seen;
        end
    end

    a_idle_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && i_is_last |=> r_bytes_needed == 2'd0 && r_bytes_seen == 2'd0)
        else $error("sequence still pending after end of string");
    a_seen_tracks_needed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_bytes_needed == 2'd0) == (r_bytes_seen == 2'd0))
        else $error("bytes seen and bytes needed out of step");
    a_seq_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bytes_needed != 2'd0 |-> ({1'b0, r_bytes_needed} + {1'b0, r_bytes_seen}) <= 3'd4)
        else $error("pending sequence longer than four bytes");

endmodule

/* rtl/u8u16_back.sv */
// Emitter back: takes one work list from the queue and hands out its code
// units one per cycle while the output is ready. Uses u8u16_pkg.
module u8u16_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_q_valid,
    input  u8u16_pkg::t_cmd             i_q_cmd,
    output logic                        o_q_pop,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [u8u16_pkg::WORD_W-1:0] o_out_word,
    output logic                        o_last_of_run
);
    import u8u16_pkg::*;

    t_cmd             r_cmd;
    logic             r_busy;
    logic [IDX_W-1:0] r_idx;
    logic             w_done;
    logic             w_load;

    assign o_valid       = r_busy;
    assign o_out_word    = r_cmd.word[r_idx];
    assign o_last_of_run = (r_idx == r_cmd.last_idx);
    assign w_done        = r_busy && i_ready && o_last_of_run;
    assign w_load        = (!r_busy || w_done) && i_q_valid;
    assign o_q_pop       = w_load;

    // Control: busy flag and word index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (w_load) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (w_done) begin
            r_busy <= 1'b0;
        end else if (r_busy && i_ready) begin
            r_idx <= r_idx + 1'b1;
        end
    end

    // Work list register
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_cmd <= i_q_cmd;
        end
    end

    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_idx <= r_cmd.last_idx)
        else $error("word index past end of work list");
    a_list_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && !w_done |=> $stable(r_cmd.last_idx) && r_busy)
        else $error("work list changed before its last word went out");
    a_pop_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |-> i_q_valid && (!r_busy || w_done))
        else $error("queue popped while a work list is in progress");

endmodule

/* rtl/utf8_to_utf16_transcoder.sv */
// UTF-8 to UTF-16 transcoder: takes one byte per cycle unless the queue is
// full and emits UTF-16 code units, each word with a flag on the last word
// caused by its byte. A byte that yields one word (ASCII, or the final byte
// of a BMP character) goes in and out at one per cycle sustained while the
// output is ready; a byte that yields k words (a surrogate pair, or '?' bursts
// from cut-off sequences and end of string, up to four) holds the output for
// its k words, and the input keeps flowing until the QUEUE_DEPTH-entry queue
// between decoder and emitter is full. The emitter, one word per ready cycle,
// sets the rate. Bytes that only start or extend a sequence give no word.
// Depends on u8u16_pkg, u8u16_front, u8u16_queue and u8u16_back.
module utf8_to_utf16_transcoder #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [7:0]                   i_in_byte,
    input  logic                         i_is_last,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [u8u16_pkg::WORD_W-1:0] o_out_word,
    output logic                         o_last_of_run
);
    import u8u16_pkg::*;

    t_cmd w_push_cmd;
    t_cmd w_head_cmd;
    logic w_push;
    logic w_full;
    logic w_pop;
    logic w_q_valid;

    // Decoder front
    u8u16_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_in_byte (i_in_byte),
        .i_is_last (i_is_last),
        .i_q_full  (w_full),
        .o_push    (w_push),
        .o_cmd     (w_push_cmd)
    );

    // Work-list queue
    u8u16_queue #(
        .WIDTH ($bits(t_cmd)),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_cmd),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_data  (w_head_cmd)
    );

    // Emitter back
    u8u16_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (w_q_valid),
        .i_q_cmd       (w_head_cmd),
        .o_q_pop       (w_pop),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_out_word    (o_out_word),
        .o_last_of_run (o_last_of_run)
    );

endmodule

/* tb/sv/transcode_monitor.sv */
// Watches both channels of the UTF-8 to UTF-16 transcoder, predicts the words
// that each accepted byte should cause and compares them as they leave.
// Depends on u8u16_pkg for widths and the surrogate and '?' constants.
module transcode_monitor (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_byte_valid,
    input  logic                         i_byte_ready,
    input  logic [u8u16_pkg::BYTE_W-1:0] i_byte,
    input  logic                         i_byte_last,
    input  logic                         i_word_valid,
    input  logic                         i_word_ready,
    input  logic [u8u16_pkg::WORD_W-1:0] i_word,
    input  logic                         i_word_last,
    output int                           o_fail_count,
    output int                           o_words_pending,
    output int                           o_words_seen
);
    import u8u16_pkg::*;

    localparam logic [CODE_W-1:0] CODE_MAX = 21'h10FFFF;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              last;
    } t_unit;

    // Decoder state as the block should hold it
    logic [CODE_W-1:0] seq_acc;
    logic [1:0]        seq_need;
    logic [1:0]        seq_seen;

    // Words caused by the byte being decoded, and the queue of words still due
    logic [WORD_W-1:0] run_words [MAX_WORDS];
    int                run_len;
    t_unit             expected_units [$];
    t_unit             head;
    int                fail_count;
    int                words_seen;

    function automatic void add_word(input logic [WORD_W-1:0] w);
        if (run_len < MAX_WORDS) begin
            run_words[run_len] = w;
        end
        run_len++;
    endfunction

    // BMP value as is, supplementary value as a surrogate pair, beyond that '?'
    function automatic void add_code(input logic [CODE_W-1:0] cp);
        logic [CODE_W-1:0] off;
        if (cp <= 21'h00FFFF) begin
            add_word(cp[WORD_W-1:0]);
        end else if (cp <= CODE_MAX) begin
            off = cp - 21'h010000;
            add_word(HI_SURR | {6'b0, off[19:10]});
            add_word(LO_SURR | {6'b0, off[9:0]});
        end else begin
            add_word(QMARK);
        end
    endfunction

    // One '?' for each byte of the pending sequence, then back to idle
    function automatic void flush_seq();
        for (int k = 0; k < seq_seen; k++) begin
            add_word(QMARK);
        end
        seq_acc  = '0;
        seq_need = '0;
        seq_seen = '0;
    endfunction

    function automatic void decode_byte(input logic [BYTE_W-1:0] b, input logic last);
        bit    fresh;
        int    n;
        t_unit u;
        run_len = 0;
        fresh   = 1'b1;
        // Continuation extends the sequence, anything else cuts it off
        if (seq_need != 0) begin
            if (b[7:6] == 2'b10) begin
                fresh    = 1'b0;
                seq_acc  = {seq_acc[14:0], b[5:0]};
                seq_need = seq_need - 2'd1;
                seq_seen = seq_seen + 2'd1;
                if (seq_need == 0) begin
                    add_code(seq_acc);
                    seq_acc  = '0;
                    seq_seen = '0;
                end
            end else begin
                flush_seq();
            end
        end
        // Byte taken afresh: ASCII, a lead, or a stray byte
        if (fresh) begin
            if (!b[7]) begin
                add_word({8'h00, b});
            end else if (b[7:5] == 3'b110) begin
                seq_acc  = {16'b0, b[4:0]};
                seq_need = 2'd1;
                seq_seen = 2'd1;
            end else if (b[7:4] == 4'b1110) begin
                seq_acc  = {17'b0, b[3:0]};
                seq_need = 2'd2;
                seq_seen = 2'd1;
            end else if (b[7:3] == 5'b11110) begin
                seq_acc  = {18'b0, b[2:0]};
                seq_need = 2'd3;
                seq_seen = 2'd1;
            end else begin
                add_word(QMARK);
            end
        end
        if (last && seq_need != 0) begin
            flush_seq();
        end
        // Queue the run, end flag on its final word
        n = (run_len > MAX_WORDS) ? MAX_WORDS : run_len;
        for (int k = 0; k < n; k++) begin
            u.word = run_words[k];
            u.last = (k == n - 1);
            expected_units.push_back(u);
        end
    endfunction

    // Check leaving words first: they belong to bytes taken earlier
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            seq_acc    = '0;
            seq_need   = '0;
            seq_seen   = '0;
            fail_count = 0;
            words_seen = 0;
            expected_units.delete();
        end else begin
            if (i_word_valid && i_word_ready) begin
                words_seen++;
                if (expected_units.size() == 0) begin
                    $error("out_word %h arrived with no word expected", i_word);
                    fail_count++;
                end else begin
                    head = expected_units.pop_front();
                    if (i_word !== head.word) begin
                        $error("out_word mismatch: expected %h, actual %h",
                               head.word, i_word);
                        fail_count++;
                    end
                    if (i_word_last !== head.last) begin
                        $error("last_of_run mismatch: expected %b, actual %b",
                               head.last, i_word_last);
                        fail_count++;
                    end
                end
            end
            if (i_byte_valid && i_byte_ready) begin
                decode_byte(i_byte, i_byte_last);
            end
        end
        o_fail_count    <= fail_count;
        o_words_seen    <= words_seen;
        o_words_pending <= expected_units.size();
    end

endmodule

/* tb/sv/tb.sv */
// Top of the transcoder testbench: clock, reset, byte stimulus, word-side
// stalls, watchdog and verdict. Depends on u8u16_pkg, the transcoder RTL and
// transcode_monitor, which does all prediction and checking.
module tb;

    import u8u16_pkg::*;

    localparam int RANDOM_ITEMS = 136;
    localparam int QUIET_LIMIT  = 1000;

    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              i_valid       = 1'b0;
    logic              i_ready       = 1'b0;
    logic [BYTE_W-1:0] i_in_byte     = '0;
    logic              i_is_last     = 1'b0;
    logic              o_ready;
    logic              o_valid;
    logic [WORD_W-1:0] o_out_word;
    logic              o_last_of_run;

    int fail_count;
    int words_pending;
    int words_seen;
    int bytes_sent     = 0;
    int directed_count = 0;
    int tx_pct         = 0;
    int rx_pct         = 0;
    int rx_stall_left  = 0;
    int rx_stall_len;
    int quiet_cycles   = 0;

    // Directed bytes, bit 8 is the end-of-string flag
    logic [8:0] directed_items [25] = '{
        9'h000, 9'h07F,                 // ASCII extremes
        9'h0DF, 9'h0BF,                 // highest two-byte value
        9'h0EF, 9'h0BF, 9'h0BF,         // U+FFFF
        9'h0F4, 9'h08F, 9'h0BF, 9'h0BF, // U+10FFFF, surrogate pair
        9'h0F7, 9'h0BF, 9'h0BF, 9'h0BF, // beyond U+10FFFF
        9'h080,                         // lone continuation
        9'h0FF, 9'h0F8,                 // invalid leads
        9'h0F0, 9'h080, 9'h080, 9'h1F0, // three bytes cut off, new lead flushed at end
        9'h0C2, 9'h041,                 // two-byte lead cut off by ASCII
        9'h17F                          // end flag with nothing pending
    };

    always #10 i_clk = ~i_clk;

    utf8_to_utf16_transcoder uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_in_byte    (i_in_byte),
        .i_is_last    (i_is_last),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_out_word   (o_out_word),
        .o_last_of_run(o_last_of_run)
    );

    transcode_monitor monitor (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_byte_valid   (i_valid),
        .i_byte_ready   (o_ready),
        .i_byte         (i_in_byte),
        .i_byte_last    (i_is_last),
        .i_word_valid   (o_valid),
        .i_word_ready   (i_ready),
        .i_word         (o_out_word),
        .i_word_last    (o_last_of_run),
        .o_fail_count   (fail_count),
        .o_words_pending(words_pending),
        .o_words_seen   (words_seen)
    );

    // Idle length: usually none, mostly short, now and then long
    function automatic int pick_gap(input int pct);
        if ($urandom_range(0, 99) >= pct) begin
            return 0;
        end
        if ($urandom_range(0, 9) == 0) begin
            return $urandom_range(10, 40);
        end
        return $urandom_range(1, 3);
    endfunction

    function automatic logic [7:0] cont_byte();
        logic [31:0] r;
        r = $urandom;
        return {2'b10, r[5:0]};
    endfunction

    // Word side: random stalls at the current pressure
    always @(posedge i_clk) begin
        if (rx_stall_left > 0) begin
            i_ready       <= 1'b0;
            rx_stall_left <= rx_stall_left - 1;
        end else begin
            rx_stall_len = pick_gap(rx_pct);
            if (rx_stall_len > 0) begin
                i_ready       <= 1'b0;
                rx_stall_left <= rx_stall_len - 1;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // Watchdog on cycles with no item moving on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    // Offer one byte after a random gap, hold it until taken
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = pick_gap(tx_pct);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_in_byte <= b;
        i_is_last <= last;
        do @(posedge i_clk); while (!o_ready);
        bytes_sent++;
    endtask

    // Sender holds off until every expected word has left
    task automatic wait_drained();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (words_pending != 0);
    endtask

    // One character: mostly well-formed, some stray and truncated sequences
    task automatic send_char();
        int          kind;
        int          len;
        bit          at_end;
        logic [31:0] r;
        logic [7:0]  seq [4];
        r    = $urandom;
        kind = $urandom_range(0, 99);
        len  = 1;
        for (int k = 1; k < 4; k++) begin
            seq[k] = cont_byte();
        end
        if (kind < 25) begin
            seq[0] = {1'b0, r[6:0]};
        end else if (kind < 45) begin
            seq[0] = {3'b110, r[4:0]};
            len    = 2;
        end else if (kind < 65) begin
            seq[0] = {4'b1110, r[3:0]};
            len    = 3;
        end else if (kind < 80) begin
            seq[0] = {5'b11110, r[2:0]};
            len    = 4;
        end else if (kind < 87) begin
            seq[0] = cont_byte();
        end else if (kind < 92) begin
            seq[0] = {5'b11111, r[2:0]};
        end else begin
            // truncated: the next byte or the end flag cuts it off
            len = $urandom_range(2, 4);
            case (len)
                2:       seq[0] = {3'b110, r[4:0]};
                3:       seq[0] = {4'b1110, r[3:0]};
                default: seq[0] = {5'b11110, r[2:0]};
            endcase
            len = $urandom_range(1, len - 1);
        end
        at_end = ($urandom_range(0, 7) == 0);
        for (int k = 0; k < len; k++) begin
            send_byte(seq[k], at_end && (k == len - 1));
        end
    endtask

    // Directed bytes, then four random phases of differing pressure
    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        foreach (directed_items[k]) begin
            send_byte(directed_items[k][7:0], directed_items[k][8]);
        end
        directed_count = bytes_sent;
        wait_drained();
        for (int ph = 0; ph < 4; ph++) begin
            tx_pct = ph[0] ? 35 : 0;
            rx_pct <= ph[1] ? 40 : 0;
            while (bytes_sent < directed_count + (ph + 1) * RANDOM_ITEMS / 4) begin
                send_char();
            end
            wait_drained();
        end
        // Settle with the word side open to catch any stray word
        rx_pct <= 0;
        do @(posedge i_clk); while (!i_ready);
        repeat (8) @(posedge i_clk);
        $display("Fed %0d UTF-8 bytes: %0d directed, the rest random characters",
                 bytes_sent, directed_count);
        $display("under four pacing mixes; %0d UTF-16 words compared", words_seen);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
